// ----- hdl/button_debounce_retrigger_guard_assert.svh -----
// Assertion helpers for the button debouncer.
// Each macro expects clk and rst_n in scope.
`ifndef BUTTON_DEBOUNCE_RETRIGGER_GUARD_ASSERT_SVH
`define BUTTON_DEBOUNCE_RETRIGGER_GUARD_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDRG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bdrg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bdrg_pkg;

  localparam int BUTTON_COUNT_DEF = 4;

  localparam int CNT_W      = 8;
  localparam int GUARD_W    = 16;
  localparam int TIME_W     = 32;
  localparam int DEADLINE_W = 33;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]     COUNTER_MAX  = 8'hFF;
  localparam logic [CNT_W-1:0]     DEBOUNCE_RST = 8'd4;
  localparam logic [GUARD_W-1:0]   GUARD_RST    = 16'd350;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD    = 1'd1;

  // What one button lane reports for the sample being accepted.
  typedef struct packed {
    logic stable;
    logic press;
  } lane_res_t;

endpackage

`default_nettype wire

// ----- hdl/bdrg_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One button: change counter, debounced bit and re-trigger deadline.
module bdrg_lane (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            raw,
  input  wire logic [bdrg_pkg::TIME_W-1:0]     now_ms,
  input  wire logic [bdrg_pkg::CNT_W-1:0]      debounce_count,
  input  wire logic [bdrg_pkg::GUARD_W-1:0]    guard_interval_ms,
  output bdrg_pkg::lane_res_t                  res
);

  logic                              stable_r, stable_nxt;
  logic [bdrg_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [bdrg_pkg::DEADLINE_W-1:0]   deadline_r, deadline_nxt;
  logic [bdrg_pkg::CNT_W-1:0]        cnt_inc;
  logic                              press;

  always_comb begin
    stable_nxt   = stable_r;
    cnt_nxt      = cnt_r;
    deadline_nxt = deadline_r;
    press        = 1'b0;
    cnt_inc      = (cnt_r == bdrg_pkg::COUNTER_MAX) ? cnt_r :
                   cnt_r + {{(bdrg_pkg::CNT_W - 1){1'b0}}, 1'b1};
    if (raw == stable_r) begin
      cnt_nxt = '0;
    end else if (cnt_inc < debounce_count) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt    = '0;
      stable_nxt = raw;
      // A press is reported only once the guard time has passed.
      if (raw && ({1'b0, now_ms} >= deadline_r)) begin
        press        = 1'b1;
        deadline_nxt = {1'b0, now_ms} +
                       {{(bdrg_pkg::DEADLINE_W - bdrg_pkg::GUARD_W){1'b0}}, guard_interval_ms};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r   <= 1'b0;
      cnt_r      <= '0;
      deadline_r <= '0;
    end else if (en) begin
      stable_r   <= stable_nxt;
      cnt_r      <= cnt_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  assign res.stable = stable_nxt;
  assign res.press  = press;

endmodule

`default_nettype wire

// ----- hdl/bdrg_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Collects the lanes' presses into the pending mask and hands it out on request.
module bdrg_merge #(
  parameter int BUTTON_COUNT = bdrg_pkg::BUTTON_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      take_events,
  input  bdrg_pkg::lane_res_t            lane_res [BUTTON_COUNT],
  output logic [BUTTON_COUNT-1:0]        debounced,
  output logic [BUTTON_COUNT-1:0]        new_presses,
  output logic                           marker_valid,
  output logic [BUTTON_COUNT-1:0]        marker_events
);

  logic [BUTTON_COUNT-1:0] pending_r, pending_nxt;
  logic [BUTTON_COUNT-1:0] merged;

  always_comb begin
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      debounced[b]   = lane_res[b].stable;
      new_presses[b] = lane_res[b].press;
    end
    merged        = pending_r | new_presses;
    marker_valid  = take_events && (merged != '0);
    marker_events = marker_valid ? merged : '0;
    pending_nxt   = marker_valid ? '0 : merged;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (en) begin
      pending_r <= pending_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/button_debounce_retrigger_guard.sv -----
// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// request  | in_valid, in_stall, in_raw_pressed, in_now_ms,  | into block
//          | in_take_events                                 |
// result   | out_valid, out_stall, out_debounced,           | out of block
//          | out_new_presses, out_marker_valid,             |
//          | out_marker_events                              |
// config   | cfg_we, cfg_index, cfg_wdata                   | into block
//
// One request is taken every cycle while in_stall is low. Its result is
// registered in the output register, or in the skid if the output is held.
// Per-button lanes update their state in the same cycle a request is taken.
// Synchronous reset clears all button state, the pending mask and the config
// registers to their defaults (debounce 4, guard 350 ms).
// A one-entry skid buffer sits behind the output register; in_stall rises only
// while that skid entry is occupied.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_retrigger_guard #(
  parameter int BUTTON_COUNT = bdrg_pkg::BUTTON_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [BUTTON_COUNT-1:0]             in_raw_pressed,
  input  wire logic [bdrg_pkg::TIME_W-1:0]         in_now_ms,
  input  wire logic                                in_take_events,

  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [BUTTON_COUNT-1:0]                  out_debounced,
  output logic [BUTTON_COUNT-1:0]                  out_new_presses,
  output logic                                     out_marker_valid,
  output logic [BUTTON_COUNT-1:0]                  out_marker_events,

  input  wire logic                                cfg_we,
  input  wire logic [bdrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bdrg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [bdrg_pkg::CNT_W-1:0]   debounce_r;
  logic [bdrg_pkg::GUARD_W-1:0] guard_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bdrg_pkg::DEBOUNCE_RST;
      guard_r    <= bdrg_pkg::GUARD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdrg_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata[bdrg_pkg::CNT_W-1:0];
        bdrg_pkg::REG_GUARD:    guard_r    <= cfg_wdata[bdrg_pkg::GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = in_valid && !in_stall;

  // One lane per button; each holds its own counter, stable bit and deadline.
  bdrg_pkg::lane_res_t lane_res [BUTTON_COUNT];

  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
    bdrg_lane u_lane (
      .clk               (clk),
      .rst_n             (rst_n),
      .en                (accept),
      .raw               (in_raw_pressed[b]),
      .now_ms            (in_now_ms),
      .debounce_count    (debounce_r),
      .guard_interval_ms (guard_r),
      .res               (lane_res[b])
    );
  end

  // The merge stage folds the lane presses into the pending mask.
  logic [BUTTON_COUNT-1:0] res_stable, res_presses, res_events;
  logic                    res_marker;

  bdrg_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (accept),
    .take_events    (in_take_events),
    .lane_res       (lane_res),
    .debounced      (res_stable),
    .new_presses    (res_presses),
    .marker_valid   (res_marker),
    .marker_events  (res_events)
  );

  // Output register plus a single skid entry. The skid only fills when a
  // result arrives while the output register is held by a stalled consumer.
  logic                    out_valid_r, skid_valid_r;
  logic [BUTTON_COUNT-1:0] out_stable_r, out_presses_r, out_events_r;
  logic                    out_marker_r;
  logic [BUTTON_COUNT-1:0] skid_stable_r, skid_presses_r, skid_events_r;
  logic                    skid_marker_r;
  logic                    out_fire;

  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // No request is accepted while the skid holds a result.
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_stable_r  <= skid_stable_r;
        out_presses_r <= skid_presses_r;
        out_marker_r  <= skid_marker_r;
        out_events_r  <= skid_events_r;
      end
    end else if (accept) begin
      if (!out_valid_r || out_fire) begin
        out_stable_r  <= res_stable;
        out_presses_r <= res_presses;
        out_marker_r  <= res_marker;
        out_events_r  <= res_events;
      end else begin
        skid_stable_r  <= res_stable;
        skid_presses_r <= res_presses;
        skid_marker_r  <= res_marker;
        skid_events_r  <= res_events;
      end
    end
  end

  assign in_stall           = skid_valid_r;
  assign out_valid          = out_valid_r;
  assign out_debounced      = out_stable_r;
  assign out_new_presses    = out_presses_r;
  assign out_marker_valid   = out_marker_r;
  assign out_marker_events  = out_events_r;

`include "button_debounce_retrigger_guard_assert.svh"

  // The skid is only ever filled behind an occupied output register.
  `BDRG_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  // A held result must not be overwritten while the consumer stalls.
  `BDRG_ASSERT_NEXT(a_skid_fills_on_stall, accept && out_valid_r && out_stall, skid_valid_r, "result lost on stall")
  // Reported presses are always part of the debounced state.
  `BDRG_ASSERT_IMP(a_press_is_stable, out_valid_r, (out_presses_r & ~out_stable_r) == '0, "press without stable bit")
  // Without a marker the handed-out mask reads as zero.
  `BDRG_ASSERT_IMP(a_marker_zero, out_valid_r && !out_marker_r, out_events_r == '0, "events without marker")

endmodule

`default_nettype wire
